// ----- design/stq_pkg.sv -----
// shared constants for the sorted deadline timer queue
package stq_pkg;

    // default sizes
    localparam int DefQueueDepth  = 16;
    localparam int DefThreadBits  = 16;

    // request function codes
    localparam logic [1:0] FUNC_TICK = 2'd0;
    localparam logic [1:0] FUNC_REG  = 2'd1;
    localparam logic [1:0] FUNC_READ = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_NOTIFY = 2'd0;
    localparam logic [1:0] KIND_QUEUED = 2'd1;
    localparam logic [1:0] KIND_FULL   = 2'd2;
    localparam logic [1:0] KIND_REPORT = 2'd3;

    // pending result held between sequencer and output register
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] tid;
        logic [31:0] bits;
        logic        last;
    } t_result;

endpackage

// ----- design/stq_ram.sv -----
// generic single write port ram with registered read
module stq_ram #(
    parameter int Width = 8,
    parameter int Depth = 16,
    localparam int AW = (Depth > 1) ? $clog2(Depth) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [Width-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [Width-1:0] o_rdata
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/sorted_deadline_timer_queue.sv -----
// top level of the sorted deadline timer queue
//
//  channel  direction  handshake                 payload
//  in       request    i_in_valid / o_in_ready   i_func i_deadline i_thread_id i_notify_bits
//  out      result     o_out_valid / i_out_ready o_kind o_thread_id_res o_notify_bits_res
//                                                o_counter_value o_last
//
// one request at a time; the queue sits in a ring buffer ram (head pointer, count)
// tick: each released entry takes a read, a compare and an emit step, then a report follows
// insert: each shifted entry takes a read and a compare-and-write step (tail-to-head scan)
// read counter, immediate notify and reject go straight from idle to the emit state
// synchronous active-low reset clears counter, count, head and output valid
// a stalled output holds the sequencer in its emit state; no result is dropped
module sorted_deadline_timer_queue
    import stq_pkg::*;
#(
    parameter int QUEUE_DEPTH    = DefQueueDepth,
    parameter int THREAD_ID_BITS = DefThreadBits
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_func,
    input  logic [31:0] i_deadline,
    input  logic [15:0] i_thread_id,
    input  logic [31:0] i_notify_bits,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_kind,
    output logic [15:0] o_thread_id_res,
    output logic [31:0] o_notify_bits_res,
    output logic [31:0] o_counter_value,
    output logic        o_last
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1) + 1;
    localparam int TB = THREAD_ID_BITS;
    localparam int EW = 64 + TB;
    localparam logic [CW-1:0] DepthC = CW'(QUEUE_DEPTH);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EMIT = 3'd1;
    localparam logic [2:0] S_TRD  = 3'd2;
    localparam logic [2:0] S_TCHK = 3'd3;
    localparam logic [2:0] S_IRD  = 3'd4;
    localparam logic [2:0] S_ICHK = 3'd5;
    localparam logic [2:0] S_IWR  = 3'd6;

    logic [2:0]    r_state, n_state;
    logic [31:0]   r_tick, n_tick;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_idx, n_idx;
    t_result       r_pend, n_pend;
    logic [31:0]   r_dl;
    logic [TB-1:0] r_tid;
    logic [31:0]   r_bits;

    logic          r_ovalid, n_ovalid;
    t_result       r_out, n_out;

    logic          in_acc, out_free;
    logic [31:0]   in_tid32;
    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [EW-1:0] wdata, rdata;
    logic [31:0]   rd_dl;
    logic [CW-1:0] idx_m1;

    // ring position of a logical slot
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head, input logic [CW-1:0] l);
        logic [CW-1:0] s;
        s = CW'(head) + l;
        if (s >= DepthC) begin
            s = s - DepthC;
        end
        return s[AW-1:0];
    endfunction

    assign in_acc   = i_in_valid && o_in_ready;
    assign out_free = !r_ovalid || i_out_ready;
    assign in_tid32 = {16'd0, i_thread_id};
    assign rd_dl    = rdata[EW-1:TB+32];
    assign idx_m1   = r_idx - CW'(1);
    assign o_in_ready = (r_state == S_IDLE);

    stq_ram #(.Width(EW), .Depth(QUEUE_DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_tick   = r_tick;
        n_count  = r_count;
        n_head   = r_head;
        n_idx    = r_idx;
        n_pend   = r_pend;
        n_ovalid = r_ovalid && !i_out_ready;
        n_out    = r_out;
        we       = 1'b0;
        waddr    = phys(r_head, r_idx);
        wdata    = {r_dl, r_tid, r_bits};
        raddr    = (r_state == S_IRD) ? phys(r_head, idx_m1) : r_head;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    priority if (i_func == FUNC_TICK) begin
                        n_tick  = r_tick + 32'd1;
                        n_state = S_TRD;
                    end else if (i_func == FUNC_REG) begin
                        priority if (i_deadline <= r_tick) begin
                            n_pend  = '{kind: KIND_NOTIFY, tid: 32'(in_tid32[TB-1:0]),
                                        bits: i_notify_bits, last: 1'b1};
                            n_state = S_EMIT;
                        end else if (r_count >= DepthC) begin
                            n_pend  = '{kind: KIND_FULL, tid: '0, bits: '0, last: 1'b1};
                            n_state = S_EMIT;
                        end else begin
                            n_idx   = r_count;
                            n_state = (r_count == '0) ? S_IWR : S_IRD;
                        end
                    end else if (i_func == FUNC_READ) begin
                        n_pend  = '{kind: KIND_REPORT, tid: '0, bits: '0, last: 1'b1};
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_out    = r_pend;
                    n_state  = r_pend.last ? S_IDLE : S_TRD;
                end
            end
            S_TRD: begin
                if (r_count == '0) begin
                    n_pend  = '{kind: KIND_REPORT, tid: '0, bits: '0, last: 1'b1};
                    n_state = S_EMIT;
                end else begin
                    n_state = S_TCHK;
                end
            end
            S_TCHK: begin
                if (rd_dl <= r_tick) begin
                    n_pend  = '{kind: KIND_NOTIFY, tid: 32'(rdata[TB+31:32]),
                                bits: rdata[31:0], last: 1'b0};
                    n_head  = (r_head == AW'(QUEUE_DEPTH - 1)) ? '0 : r_head + AW'(1);
                    n_count = r_count - CW'(1);
                end else begin
                    n_pend  = '{kind: KIND_REPORT, tid: '0, bits: '0, last: 1'b1};
                end
                n_state = S_EMIT;
            end
            S_IRD: begin
                n_state = S_ICHK;
            end
            S_ICHK: begin
                we = 1'b1;
                if (rd_dl < r_dl) begin
                    n_count = r_count + CW'(1);
                    n_pend  = '{kind: KIND_QUEUED, tid: '0, bits: '0, last: 1'b1};
                    n_state = S_EMIT;
                end else begin
                    wdata   = rdata;
                    n_idx   = idx_m1;
                    n_state = (idx_m1 == '0) ? S_IWR : S_IRD;
                end
            end
            S_IWR: begin
                we      = 1'b1;
                n_count = r_count + CW'(1);
                n_pend  = '{kind: KIND_QUEUED, tid: '0, bits: '0, last: 1'b1};
                n_state = S_EMIT;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_tick   <= '0;
            r_count  <= '0;
            r_head   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_tick   <= n_tick;
            r_count  <= n_count;
            r_head   <= n_head;
            r_ovalid <= n_ovalid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_pend <= n_pend;
        r_out  <= n_out;
        if (in_acc) begin
            r_dl   <= i_deadline;
            r_tid  <= in_tid32[TB-1:0];
            r_bits <= i_notify_bits;
        end
    end

    // output register; counter is current at emit time
    logic [31:0] r_ocnt;
    always_ff @(posedge i_clk) begin
        if (r_state == S_EMIT && out_free) begin
            r_ocnt <= r_tick;
        end
    end

    assign o_out_valid       = r_ovalid;
    assign o_kind            = r_out.kind;
    assign o_thread_id_res   = r_out.tid[15:0];
    assign o_notify_bits_res = r_out.bits;
    assign o_counter_value   = r_ocnt;
    assign o_last            = r_out.last;

endmodule

// ----- test/sorted_deadline_timer_queue_test.sv -----
// testbench for the sorted deadline timer queue
`timescale 1ns / 100ps

module sorted_deadline_timer_queue_test;
    import stq_pkg::*;

    localparam int Depth = 16;

    // expected result record
    typedef struct {
        logic [1:0]  kind;
        logic [15:0] tid;
        logic [31:0] bits;
        logic [31:0] counter;
        logic        last;
    } t_expect;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_func;
    logic [31:0] i_deadline;
    logic [15:0] i_thread_id;
    logic [31:0] i_notify_bits;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [1:0]  o_kind;
    logic [15:0] o_thread_id_res;
    logic [31:0] o_notify_bits_res;
    logic [31:0] o_counter_value;
    logic        o_last;

    sorted_deadline_timer_queue i_dut (.*);

    // predictor state
    logic [31:0] ticks;
    logic [31:0] q_deadline[$];
    logic [15:0] q_thread[$];
    logic [31:0] q_mask[$];
    t_expect     pending_results[$];
    int          errors;
    int          results_seen;
    int          notifies_seen;
    int          full_seen;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        #4000000;
        $display("FAIL");
        $finish;
    end

    function automatic t_expect mk(logic [1:0] k, logic [15:0] t, logic [31:0] b,
                                   logic l);
        t_expect e;
        e.kind = k;
        e.tid = t;
        e.bits = b;
        e.counter = ticks;
        e.last = l;
        return e;
    endfunction

    // update the timer queue model and queue what it emits
    function automatic void predict_timer(logic [1:0] f, logic [31:0] dl,
                                          logic [15:0] tid, logic [31:0] bits);
        int pos;
        if (f == FUNC_TICK) begin
            ticks = ticks + 32'd1;
            while (q_deadline.size() > 0 && q_deadline[0] <= ticks) begin
                pending_results.push_back(mk(KIND_NOTIFY, q_thread[0], q_mask[0], 1'b0));
                void'(q_deadline.pop_front());
                void'(q_thread.pop_front());
                void'(q_mask.pop_front());
            end
            pending_results.push_back(mk(KIND_REPORT, '0, '0, 1'b1));
        end else if (f == FUNC_REG) begin
            if (dl <= ticks) begin
                pending_results.push_back(mk(KIND_NOTIFY, tid, bits, 1'b1));
            end else if (q_deadline.size() >= Depth) begin
                pending_results.push_back(mk(KIND_FULL, '0, '0, 1'b1));
            end else begin
                pos = 0;
                while (pos < q_deadline.size() && q_deadline[pos] < dl) pos++;
                q_deadline.insert(pos, dl);
                q_thread.insert(pos, tid);
                q_mask.insert(pos, bits);
                pending_results.push_back(mk(KIND_QUEUED, '0, '0, 1'b1));
            end
        end else if (f == FUNC_READ) begin
            pending_results.push_back(mk(KIND_REPORT, '0, '0, 1'b1));
        end
    endfunction

    // send one request, with a random gap before it at burst ends
    int burst_left;
    task automatic send_request(logic [1:0] f, logic [31:0] dl, logic [15:0] tid,
                                logic [31:0] bits);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid    <= 1'b1;
        i_func        <= f;
        i_deadline    <= dl;
        i_thread_id   <= tid;
        i_notify_bits <= bits;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_timer(f, dl, tid, bits);
    endtask

    // receiver stall pattern: phases of always ready and phases of random stalls
    initial begin
        int phase;
        i_out_ready = 1'b0;
        phase = 0;
        forever begin
            @(posedge i_clk);
            phase = (phase + 1) % 300;
            if (phase < 100) i_out_ready <= 1'b1;
            else if (phase < 200) i_out_ready <= ($urandom_range(0, 3) != 0);
            else i_out_ready <= ($urandom_range(0, 4) == 0);
        end
    end

    // compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        t_expect e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("unexpected result kind %0d", o_kind);
                errors++;
            end else begin
                e = pending_results.pop_front();
                if (e.kind == KIND_NOTIFY) notifies_seen++;
                if (e.kind == KIND_FULL) full_seen++;
                if (o_kind !== e.kind) begin
                    $error("kind expected %0d actual %0d", e.kind, o_kind);
                    errors++;
                end
                if (o_thread_id_res !== e.tid) begin
                    $error("thread_id_res expected %h actual %h", e.tid, o_thread_id_res);
                    errors++;
                end
                if (o_notify_bits_res !== e.bits) begin
                    $error("notify_bits_res expected %h actual %h", e.bits,
                           o_notify_bits_res);
                    errors++;
                end
                if (o_counter_value !== e.counter) begin
                    $error("counter_value expected %h actual %h", e.counter,
                           o_counter_value);
                    errors++;
                end
                if (o_last !== e.last) begin
                    $error("last expected %b actual %b", e.last, o_last);
                    errors++;
                end
            end
        end
    end

    // random deadline close to the counter, sometimes at or below it or anywhere in range
    function automatic logic [31:0] near_deadline();
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: return ticks;
            2: return ticks - $urandom_range(0, 5);
            default: return ticks + $urandom_range(1, 12);
        endcase
    endfunction

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    // extremes, each function, immediate notify, fill to full, big release
    task automatic test_directed();
        int i;
        send_request(FUNC_READ, '0, '0, '0);
        send_request(FUNC_REG, 32'd0, 16'hFFFF, 32'hFFFF_FFFF);
        send_request(FUNC_REG, 32'hFFFF_FFFF, 16'h0000, 32'h0000_0000);
        send_request(2'd3, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
        for (i = 0; i < 16; i++)
            send_request(FUNC_REG, 32'd2 + (i % 3), 16'(i) ^ 16'hA5A5, $urandom());
        send_request(FUNC_REG, 32'd5, 16'h1234, 32'h8000_0001);
        send_request(FUNC_TICK, '0, '0, '0);
        send_request(FUNC_TICK, '0, '0, '0);
        send_request(FUNC_TICK, '0, '0, '0);
        send_request(FUNC_READ, '0, '0, '0);
        wait_drained();
    endtask

    // mixed traffic: mostly registrations and ticks, with some reads and unused codes
    task automatic test_random_traffic(int n);
        int i;
        int r;
        for (i = 0; i < n; i++) begin
            r = $urandom_range(0, 19);
            if (r < 9) send_request(FUNC_REG, near_deadline(), 16'($urandom()), $urandom());
            else if (r < 16) send_request(FUNC_TICK, $urandom(), 16'($urandom()), $urandom());
            else if (r < 19) send_request(FUNC_READ, $urandom(), 16'($urandom()), $urandom());
            else send_request(2'd3, $urandom(), 16'($urandom()), $urandom());
        end
        wait_drained();
    endtask

    // bring the counter near the wrap using only ticks is too slow, so check
    // wrap-blind comparison with deadlines far above the counter
    task automatic test_full_churn(int n);
        int i;
        for (i = 0; i < n; i++) begin
            if ($urandom_range(0, 3) == 0) send_request(FUNC_TICK, '0, '0, '0);
            else send_request(FUNC_REG, ($urandom_range(0, 4) == 0) ? 32'hFFFF_FFF0
                              + $urandom_range(0, 15) : ticks + $urandom_range(1, 30),
                              16'($urandom()), $urandom());
        end
        wait_drained();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_func = FUNC_READ;
        i_deadline = '0;
        i_thread_id = '0;
        i_notify_bits = '0;
        ticks = '0;
        errors = 0;
        results_seen = 0;
        notifies_seen = 0;
        full_seen = 0;
        burst_left = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_traffic(300);
        test_full_churn(130);
        $display("covered %0d results: %0d notifies, %0d rejects, counter at %0d",
                 results_seen, notifies_seen, full_seen, ticks);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ----- files.f -----
design/stq_pkg.sv
design/stq_ram.sv
design/sorted_deadline_timer_queue.sv
test/sorted_deadline_timer_queue_test.sv
